// ===== sv/adaptive_weighted_3x3_smoother_macros.svh =====
// Assertion macros for the adaptive weighted 3x3 smoother.
// Each use needs clock and reset in scope; no other dependencies.
`ifndef ADAPTIVE_WEIGHTED_3X3_SMOOTHER_MACROS_SVH
`define ADAPTIVE_WEIGHTED_3X3_SMOOTHER_MACROS_SVH

// ante implies cons in the same cycle
`define AWSM_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("awsm: implication violated");

// cond must never hold outside reset
`define AWSM_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("awsm: forbidden condition seen");

`endif

// ===== sv/awsm_pkg.sv =====
// Shared types, register indexes and tables for the adaptive 3x3 smoother.
// No dependencies.
`default_nettype none
package awsm_pkg;

   localparam int AWSM_MAX_SIDE = 4096;
   localparam int AWSM_LATENCY  = 12;
   localparam int AWSM_RECIP_SHIFT = 18;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_THRESHOLD    = 2'd2,
      CSR_ADAPTIVE     = 2'd3
   } awsm_csr_type;

   typedef logic [8:0][31:0] awsm_win_type;

   typedef struct packed {
      awsm_win_type win;
      logic [8:0]   kept;
   } awsm_beat_type;

   // window weights 1 2 1 / 2 8 2 / 1 2 1
   function automatic logic [3:0] awsm_weight(input logic [3:0] k);
      logic [3:0] w;
      unique case (k)
         4'd4: w = 4'd8;
         4'd1, 4'd3, 4'd5, 4'd7: w = 4'd2;
         default: w = 4'd1;
      endcase
      return w;
   endfunction

   // floor(2^18 / d) + 1: exact floor quotient for dividends below 8192
   function automatic logic [18:0] awsm_recip(input logic [4:0] d);
      logic [18:0] r;
      unique case (d)
         5'd1:  r = 19'd262145;
         5'd2:  r = 19'd131073;
         5'd3:  r = 19'd87382;
         5'd4:  r = 19'd65537;
         5'd5:  r = 19'd52429;
         5'd6:  r = 19'd43691;
         5'd7:  r = 19'd37450;
         5'd8:  r = 19'd32769;
         5'd9:  r = 19'd29128;
         5'd10: r = 19'd26215;
         5'd11: r = 19'd23832;
         5'd12: r = 19'd21846;
         5'd13: r = 19'd20165;
         5'd14: r = 19'd18725;
         5'd15: r = 19'd17477;
         5'd16: r = 19'd16385;
         5'd17: r = 19'd15421;
         5'd18: r = 19'd14564;
         5'd19: r = 19'd13798;
         5'd20: r = 19'd13108;
         default: r = 19'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/awsm_reject.sv =====
// One channel of outlier rejection: kept-sample sum, then distance test.
// Depends on awsm_pkg.
`default_nettype none
module awsm_reject import awsm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [1:0]    chan_sel,
   input  wire logic [7:0]    threshold,
   input  wire logic          enable,
   input  wire logic          in_valid,
   input  wire awsm_beat_type in_beat,
   output logic               out_valid,
   output awsm_beat_type      out_beat
);

   logic          a_valid_ff;
   awsm_beat_type a_beat_ff;
   logic [11:0]   a_sum_ff, a_sum_in;
   logic [3:0]    a_n_ff, a_n_in;
   logic          b_valid_ff;
   awsm_beat_type b_beat_ff, b_beat_in;

   // stage A: sum and count of kept samples
   always_comb begin
      a_sum_in = '0;
      a_n_in   = '0;
      for (int k = 0; k < 9; k++) begin
         if (in_beat.kept[k]) begin
            a_sum_in = a_sum_in + 12'(in_beat.win[k][{chan_sel, 3'b000} +: 8]);
            a_n_in   = a_n_in + 4'd1;
         end
      end
   end

   // stage B: drop samples with |n*v - sum| > T*n
   always_comb begin
      logic [11:0] prod;
      logic [12:0] diff;
      logic [11:0] dev;
      logic [11:0] lim;
      b_beat_in = a_beat_ff;
      lim = 12'(threshold) * 12'(a_n_ff);
      for (int k = 0; k < 9; k++) begin
         prod = 12'(a_n_ff) * 12'(a_beat_ff.win[k][{chan_sel, 3'b000} +: 8]);
         diff = {1'b0, prod} - {1'b0, a_sum_ff};
         dev  = diff[12] ? 12'(-diff) : diff[11:0];
         if (enable && a_beat_ff.kept[k] && (dev > lim)) begin
            b_beat_in.kept[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
      a_beat_ff <= in_beat;
      a_sum_ff  <= a_sum_in;
      a_n_ff    <= a_n_in;
      b_beat_ff <= b_beat_in;
   end

   assign out_valid = b_valid_ff;
   assign out_beat  = b_beat_ff;

endmodule
`default_nettype wire

// ===== sv/adaptive_weighted_3x3_smoother.sv =====
// Top level of the adaptive weighted 3x3 smoother: bounds, four rejection
// passes, weighted sum, reciprocal divide. Depends on awsm_pkg, awsm_reject.
`default_nettype none
// A neighbourhood beat is taken on every clock where start is high; busy is
// always low, so one pixel enters per cycle with no gaps. Results leave in
// input order, each marked by rsp_valid for one cycle. The receiver cannot
// stall: the pipeline advances every cycle through its twelve register stages
// (bounds, two per channel of rejection, sum, multiply, output). Configuration
// writes take effect on the next cycle and must be made only while no beat is
// in flight.
module adaptive_weighted_3x3_smoother import awsm_pkg::*; #(
   parameter int MAX_SIDE = AWSM_MAX_SIDE
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_write_data,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [11:0] req_pixel_row,
   input  wire logic [11:0] req_pixel_col,
   input  wire logic [31:0] req_pixel_up_left,
   input  wire logic [31:0] req_pixel_up,
   input  wire logic [31:0] req_pixel_up_right,
   input  wire logic [31:0] req_pixel_left,
   input  wire logic [31:0] req_pixel_mid,
   input  wire logic [31:0] req_pixel_right,
   input  wire logic [31:0] req_pixel_down_left,
   input  wire logic [31:0] req_pixel_down,
   input  wire logic [31:0] req_pixel_down_right,
   output logic             rsp_valid,
   output logic [7:0]       rsp_chan0_out,
   output logic [7:0]       rsp_chan1_out,
   output logic [7:0]       rsp_chan2_out,
   output logic [7:0]       rsp_chan3_out,
   output logic             rsp_none_kept
);

   // configuration registers
   logic [12:0] width_ff, height_ff;
   logic [7:0]  thr_ff;
   logic        adapt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd4096;
         height_ff <= 13'd4096;
         thr_ff    <= 8'd32;
         adapt_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (awsm_csr_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
            CSR_THRESHOLD:    thr_ff    <= csr_write_data[7:0];
            CSR_ADAPTIVE:     adapt_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // never held off: a beat enters every cycle
   assign busy = 1'b0;

   // stage 0: bounds test, saturating the image size at MAX_SIDE
   logic          s0_valid_ff;
   awsm_beat_type s0_beat_ff, s0_beat_in;

   always_comb begin
      int w_lim;
      int h_lim;
      logic [2:0] row_ok;
      logic [2:0] col_ok;
      w_lim = (int'(width_ff) > MAX_SIDE) ? MAX_SIDE : int'(width_ff);
      h_lim = (int'(height_ff) > MAX_SIDE) ? MAX_SIDE : int'(height_ff);
      row_ok[0] = (req_pixel_row != 12'd0) && ((int'(req_pixel_row) - 1) < h_lim);
      row_ok[1] = int'(req_pixel_row) < h_lim;
      row_ok[2] = (int'(req_pixel_row) + 1) < h_lim;
      col_ok[0] = (req_pixel_col != 12'd0) && ((int'(req_pixel_col) - 1) < w_lim);
      col_ok[1] = int'(req_pixel_col) < w_lim;
      col_ok[2] = (int'(req_pixel_col) + 1) < w_lim;
      s0_beat_in.win = {req_pixel_down_right, req_pixel_down, req_pixel_down_left,
                        req_pixel_right, req_pixel_mid, req_pixel_left,
                        req_pixel_up_right, req_pixel_up, req_pixel_up_left};
      for (int k = 0; k < 9; k++) begin
         s0_beat_in.kept[k] = row_ok[k / 3] & col_ok[k % 3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start & ~busy;
      end
      s0_beat_ff <= s0_beat_in;
   end

   // four rejection passes, channel 0 first; exclusions accumulate
   logic          rj_valid [5];
   awsm_beat_type rj_beat  [5];

   assign rj_valid[0] = s0_valid_ff;
   assign rj_beat[0]  = s0_beat_ff;

   for (genvar c = 0; c < 4; c++) begin : g_reject
      awsm_reject u_reject (
         .clock     (clock),
         .reset     (reset),
         .chan_sel  (2'(c)),
         .threshold (thr_ff),
         .enable    (adapt_ff),
         .in_valid  (rj_valid[c]),
         .in_beat   (rj_beat[c]),
         .out_valid (rj_valid[c+1]),
         .out_beat  (rj_beat[c+1])
      );
   end

   // weighted sums over the final kept set
   logic              fs_valid_ff;
   logic [3:0][12:0]  fs_sum_ff, fs_sum_in;
   logic [4:0]        fs_wsum_ff, fs_wsum_in;
   logic              fs_any_ff;
   logic [31:0]       fs_mid_ff;

   always_comb begin
      fs_sum_in  = '0;
      fs_wsum_in = '0;
      for (int k = 0; k < 9; k++) begin
         if (rj_beat[4].kept[k]) begin
            fs_wsum_in = fs_wsum_in + 5'(awsm_weight(4'(k)));
            for (int c = 0; c < 4; c++) begin
               fs_sum_in[c] = fs_sum_in[c] +
                  13'(awsm_weight(4'(k))) * 13'(rj_beat[4].win[k][8*c +: 8]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_valid_ff <= 1'b0;
      end else begin
         fs_valid_ff <= rj_valid[4];
      end
      fs_sum_ff  <= fs_sum_in;
      fs_wsum_ff <= fs_wsum_in;
      fs_any_ff  <= |rj_beat[4].kept;
      fs_mid_ff  <= rj_beat[4].win[4];
   end

   // divide by the weight total: multiply by its reciprocal
   logic             mu_valid_ff;
   logic [3:0][31:0] mu_prod_ff;
   logic             mu_any_ff;
   logic [31:0]      mu_mid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_valid_ff <= 1'b0;
      end else begin
         mu_valid_ff <= fs_valid_ff;
      end
      for (int c = 0; c < 4; c++) begin
         mu_prod_ff[c] <= 32'(fs_sum_ff[c]) * 32'(awsm_recip(fs_wsum_ff));
      end
      mu_any_ff <= fs_any_ff;
      mu_mid_ff <= fs_mid_ff;
   end

   // output register: fall back to the centre pixel when nothing was kept;
   // in plain mode alpha always passes from the centre
   logic            out_valid_ff;
   logic [3:0][7:0] out_chan_ff, out_chan_in;
   logic            out_none_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         out_chan_in[c] = mu_any_ff ?
            mu_prod_ff[c][AWSM_RECIP_SHIFT +: 8] : mu_mid_ff[8*c +: 8];
      end
      if (!adapt_ff) begin
         out_chan_in[3] = mu_mid_ff[31:24];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= mu_valid_ff;
      end
      out_chan_ff <= out_chan_in;
      out_none_ff <= ~mu_any_ff;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_chan0_out = out_chan_ff[0];
   assign rsp_chan1_out = out_chan_ff[1];
   assign rsp_chan2_out = out_chan_ff[2];
   assign rsp_chan3_out = out_chan_ff[3];
   assign rsp_none_kept = out_none_ff;

endmodule
`default_nettype wire

// ===== sv/awsm_checker.sv =====
// Port-level checks for the adaptive 3x3 smoother, bound to the top level.
// Depends on awsm_pkg and the assertion macro header.
`default_nettype none
`include "adaptive_weighted_3x3_smoother_macros.svh"
module awsm_checker import awsm_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [31:0] req_pixel_mid,
   input wire logic        rsp_valid,
   input wire logic [7:0]  rsp_chan0_out,
   input wire logic [7:0]  rsp_chan1_out,
   input wire logic        rsp_none_kept
);

   `AWSM_ASSERT_NEVER(a_never_busy, busy)
   `AWSM_ASSERT_IMPLIES(a_rsp_has_req, rsp_valid, $past(start && !busy, AWSM_LATENCY))
   `AWSM_ASSERT_IMPLIES(a_empty_c0, rsp_valid && rsp_none_kept, rsp_chan0_out == $past(req_pixel_mid[7:0], AWSM_LATENCY))
   `AWSM_ASSERT_IMPLIES(a_empty_c1, rsp_valid && rsp_none_kept, rsp_chan1_out == $past(req_pixel_mid[15:8], AWSM_LATENCY))

endmodule

bind adaptive_weighted_3x3_smoother awsm_checker u_awsm_checker (.*);
`default_nettype wire

// ===== tb/tb_adaptive_weighted_3x3_smoother.sv =====
// Self-checking testbench for adaptive_weighted_3x3_smoother: clocked driver and monitor
// around an in-bench predictor of the bounds test, outlier rejection and weighted mean.
// Depends on awsm_pkg and the smoother RTL.
`default_nettype none
module tb_adaptive_weighted_3x3_smoother;
   import awsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [11:0]  row;
      logic [11:0]  col;
      awsm_win_type win;
   } nbhd_t;

   typedef struct {
      logic [7:0] chan [4];
      logic       none_kept;
   } pixel_out_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [12:0] csr_write_data = 13'd0;
   logic        start = 1'b0;
   logic        busy;
   logic [11:0] req_pixel_row = '0;
   logic [11:0] req_pixel_col = '0;
   logic [31:0] req_pix [9] = '{default: '0};
   logic        rsp_valid;
   logic [7:0]  rsp_chan0_out, rsp_chan1_out, rsp_chan2_out, rsp_chan3_out;
   logic        rsp_none_kept;

   // settings mirrored for the predictor
   logic [12:0] cfg_width  = 13'd4096;
   logic [12:0] cfg_height = 13'd4096;
   logic [7:0]  cfg_thresh = 8'd32;
   logic        cfg_adapt  = 1'b1;

   nbhd_t      pending_nbhds [$];
   pixel_out_t expected_pixels [$];
   nbhd_t      nbhd_on_port;
   int         gap_left = 0;
   bit         calm_phase = 1'b0;
   int         mismatches = 0;
   int         beats_sent = 0;
   int         results_seen = 0;
   int         empty_results = 0;

   always #5 clock = ~clock;

   adaptive_weighted_3x3_smoother DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .start(start), .busy(busy),
      .req_pixel_row(req_pixel_row), .req_pixel_col(req_pixel_col),
      .req_pixel_up_left(req_pix[0]), .req_pixel_up(req_pix[1]),
      .req_pixel_up_right(req_pix[2]), .req_pixel_left(req_pix[3]),
      .req_pixel_mid(req_pix[4]), .req_pixel_right(req_pix[5]),
      .req_pixel_down_left(req_pix[6]), .req_pixel_down(req_pix[7]),
      .req_pixel_down_right(req_pix[8]),
      .rsp_valid(rsp_valid),
      .rsp_chan0_out(rsp_chan0_out), .rsp_chan1_out(rsp_chan1_out),
      .rsp_chan2_out(rsp_chan2_out), .rsp_chan3_out(rsp_chan3_out),
      .rsp_none_kept(rsp_none_kept)
   );

   function automatic int sample_of(logic [31:0] px, int ch);
      return int'(px[8*ch +: 8]);
   endfunction

   // Smooth one neighbourhood under the current mirrored settings.
   function automatic pixel_out_t smooth_nbhd(nbhd_t nb);
      pixel_out_t res;
      bit kept [9];
      bit any_kept;
      int w, h, r, c, sum, n, d, wsum, nch;
      int weight [9] = '{1, 2, 1, 2, 8, 2, 1, 2, 1};
      w = (cfg_width > 13'd4096) ? 4096 : int'(cfg_width);
      h = (cfg_height > 13'd4096) ? 4096 : int'(cfg_height);
      // drop neighbours outside the image, the centre included
      for (int k = 0; k < 9; k++) begin
         r = int'(nb.row) + k / 3 - 1;
         c = int'(nb.col) + k % 3 - 1;
         kept[k] = (r >= 0 && r < h && c >= 0 && c < w);
      end
      if (cfg_adapt) begin
         // rejection builds up channel by channel; an empty set drops nothing
         for (int ch = 0; ch < 4; ch++) begin
            sum = 0;
            n = 0;
            for (int k = 0; k < 9; k++) begin
               if (kept[k]) begin
                  sum += sample_of(nb.win[k], ch);
                  n++;
               end
            end
            if (n != 0) begin
               for (int k = 0; k < 9; k++) begin
                  if (kept[k]) begin
                     d = n * sample_of(nb.win[k], ch) - sum;
                     if (d < 0) d = -d;
                     if (d > int'(cfg_thresh) * n) kept[k] = 1'b0;
                  end
               end
            end
         end
      end
      any_kept = 1'b0;
      for (int k = 0; k < 9; k++) if (kept[k]) any_kept = 1'b1;
      for (int ch = 0; ch < 4; ch++) res.chan[ch] = nb.win[4][8*ch +: 8];
      nch = cfg_adapt ? 4 : 3;
      if (any_kept) begin
         for (int ch = 0; ch < nch; ch++) begin
            sum = 0;
            wsum = 0;
            for (int k = 0; k < 9; k++) begin
               if (kept[k]) begin
                  sum += weight[k] * sample_of(nb.win[k], ch);
                  wsum += weight[k];
               end
            end
            res.chan[ch] = 8'(sum / wsum);
         end
      end
      res.none_kept = !any_kept;
      return res;
   endfunction

   // Driver: hold the beat until accepted, then advance, idle or drop start.
   always @(posedge clock) begin : driver
      nbhd_t nb;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_pixels.push_back(smooth_nbhd(nbhd_on_port));
            beats_sent++;
         end
         if (start && busy) begin
            // hold the current beat
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_nbhds.size() > 0) begin
            nb = pending_nbhds.pop_front();
            nbhd_on_port = nb;
            req_pixel_row <= nb.row;
            req_pixel_col <= nb.col;
            for (int k = 0; k < 9; k++) req_pix[k] <= nb.win[k];
            start <= 1'b1;
            if (!calm_phase && $urandom_range(0, 7) == 0)
               gap_left = $urandom_range(1, 15);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed result meets the oldest prediction.
   always @(posedge clock) begin : monitor
      pixel_out_t want;
      logic [7:0] got [4];
      bit bad;
      if (!reset && rsp_valid) begin
         results_seen++;
         got = '{rsp_chan0_out, rsp_chan1_out, rsp_chan2_out, rsp_chan3_out};
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result with nothing predicted: %h %h %h %h nk=%b",
                        got[0], got[1], got[2], got[3], rsp_none_kept);
         end else begin
            want = expected_pixels.pop_front();
            if (want.none_kept) empty_results++;
            bad = (want.none_kept !== rsp_none_kept);
            for (int ch = 0; ch < 4; ch++) if (want.chan[ch] !== got[ch]) bad = 1'b1;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: result %0d expected %h %h %h %h nk=%b got %h %h %h %h nk=%b",
                           results_seen, want.chan[0], want.chan[1], want.chan[2],
                           want.chan[3], want.none_kept, got[0], got[1], got[2], got[3],
                           rsp_none_kept);
            end
         end
      end
   end

   task automatic write_reg(awsm_csr_type idx, logic [12:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width = value;
         CSR_IMAGE_HEIGHT: cfg_height = value;
         CSR_THRESHOLD:    cfg_thresh = value[7:0];
         CSR_ADAPTIVE:     cfg_adapt = value[0];
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_all(logic [12:0] w, logic [12:0] h, logic [12:0] t, logic [12:0] a);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_THRESHOLD, t);
      write_reg(CSR_ADAPTIVE, a);
   endtask

   // Wait for the pipeline to empty, then let the latency pass.
   task automatic drain();
      while (pending_nbhds.size() > 0 || start || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (AWSM_LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [7:0] jitter(logic [7:0] base, int spread);
      int v;
      v = int'(base) + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   // Mostly coherent windows with a few outliers, some pure noise.
   function automatic nbhd_t random_nbhd();
      nbhd_t nb;
      logic [31:0] base;
      int spread, sel, w, h;
      w = (cfg_width == 0) ? 1 : ((cfg_width > 4096) ? 4096 : int'(cfg_width));
      h = (cfg_height == 0) ? 1 : ((cfg_height > 4096) ? 4096 : int'(cfg_height));
      base = $urandom;
      spread = $urandom_range(0, 1) ? int'(cfg_thresh) + 4 : $urandom_range(0, 12);
      for (int k = 0; k < 9; k++) begin
         sel = $urandom_range(0, 9);
         if (sel < 1) begin
            nb.win[k] = $urandom;
         end else begin
            for (int ch = 0; ch < 4; ch++) nb.win[k][8*ch +: 8] = jitter(base[8*ch +: 8], spread);
            if (sel == 1) nb.win[k][8*$urandom_range(0, 3) +: 8] = 8'($urandom);
         end
      end
      case ($urandom_range(0, 4))
         0: begin nb.row = 12'($urandom); nb.col = 12'($urandom); end
         1: begin nb.row = 12'($urandom_range(0, 1)); nb.col = 12'($urandom_range(0, 2)); end
         2: begin
            nb.row = 12'(h - 1 + $urandom_range(0, 1));
            nb.col = 12'(w - 1 + $urandom_range(0, 1));
         end
         default: begin
            nb.row = 12'($urandom_range(0, h - 1));
            nb.col = 12'($urandom_range(0, w - 1));
         end
      endcase
      return nb;
   endfunction

   task automatic queue_nbhd(logic [11:0] r, logic [11:0] c, logic [31:0] fill,
                             logic [31:0] centre);
      nbhd_t nb;
      nb.row = r;
      nb.col = c;
      for (int k = 0; k < 9; k++) nb.win[k] = fill;
      nb.win[4] = centre;
      pending_nbhds.push_back(nb);
   endtask

   task automatic queue_random(int count);
      repeat (count) pending_nbhds.push_back(random_nbhd());
   endtask

   initial begin : sequencer
      nbhd_t nb;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under reset settings: extremes, corners, edges, outliers.
      queue_nbhd(12'd0, 12'd0, 32'h0000_0000, 32'h0000_0000);
      queue_nbhd(12'd4095, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_nbhd(12'd0, 12'd4095, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_nbhd(12'd4095, 12'd0, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_nbhd(12'd100, 12'd100, 32'h8080_8080, 32'h00FF_00FF);
      queue_nbhd(12'd2048, 12'd1, 32'h0102_0304, 32'hFEFD_FCFB);
      // centre alone as an outlier in each channel in turn
      for (int ch = 0; ch < 4; ch++)
         queue_nbhd(12'd50, 12'd50, 32'h4040_4040, 32'h4040_4040 ^ (32'hC0 << (8 * ch)));
      // alternating extremes: rejection can remove everything
      nb.row = 12'd10;
      nb.col = 12'd10;
      for (int k = 0; k < 9; k++) nb.win[k] = (k % 2) ? 32'hFFFF_FFFF : 32'h0000_0000;
      pending_nbhds.push_back(nb);
      nb.win[4] = 32'h1234_5678;
      pending_nbhds.push_back(nb);
      queue_random(10);
      drain();

      // Image of one pixel, zero threshold.
      set_all(13'd1, 13'd1, 13'd0, 13'd1);
      queue_nbhd(12'd0, 12'd0, 32'hAAAA_5555, 32'h5555_AAAA);
      queue_nbhd(12'd1, 12'd1, 32'hAAAA_5555, 32'h5555_AAAA);
      queue_nbhd(12'd2, 12'd2, 32'hAAAA_5555, 32'hDEAD_BEEF);
      queue_random(250);
      drain();

      // Oversized sides saturate; plain mode; junk in upper data bits.
      set_all(13'h1FFF, 13'd5000, 13'h1FFF, 13'h1FFE);
      queue_nbhd(12'd4095, 12'd4095, 32'h1122_3344, 32'h55AA_55AA);
      queue_random(280);
      drain();

      // Zero image size: nothing is ever kept.
      set_all(13'd0, 13'd0, 13'd255, 13'd1);
      queue_random(100);
      drain();
      write_reg(CSR_ADAPTIVE, 13'd0);
      queue_random(100);
      drain();

      // Several random settings, small images for frequent edges.
      repeat (4) begin
         set_all(13'($urandom_range(1, 40)), 13'($urandom_range(1, 40)),
                 13'($urandom_range(0, 255)), 13'($urandom_range(0, 1)));
         queue_random(150);
         drain();
      end
      set_all(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
              13'($urandom_range(0, 60)), 13'd1);
      queue_random(150);
      drain();

      // Final stretch back to back, no idling.
      set_all(13'd64, 13'd48, 13'd20, 13'd1);
      calm_phase = 1'b1;
      queue_random(200);
      drain();
      repeat (20) @(posedge clock);

      mismatches += expected_pixels.size();
      $display("Run covered %0d neighbourhood beats, %0d results, %0d with nothing kept,",
               beats_sent, results_seen, empty_results);
      $display("across plain and adaptive modes, tiny, zero and oversized images.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatching results", mismatches);
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("Timeout waiting for results");
      $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire
